// File: sv/swmv_pkg.sv
// ----------------------------------------------------------------------------
// swmv_pkg: shared types and constants
// Port widths and sequencer states of the sliding-window mean/variance core.
// ----------------------------------------------------------------------------
package swmv_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned MEAN_W   = 16;
  localparam int unsigned VAR_W    = 31;
  localparam int unsigned FILL_W   = 3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ,
    ST_SQ_WAIT,
    ST_SP,
    ST_SP_WAIT,
    ST_DIV,
    ST_DIV_WAIT,
    ST_DONE
  } swmv_state_e;

endpackage

// File: sv/swmv_mul.sv
// ----------------------------------------------------------------------------
// swmv_mul: bit-serial multiplier
// Shift-add over the multiplier, one bit per cycle, LSB first.
// ----------------------------------------------------------------------------
module swmv_mul #(
  parameter int unsigned AW = 16,
  parameter int unsigned BW = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [AW-1:0]    a_i,
  input  logic [BW-1:0]    b_i,
  output logic             busy_o,
  output logic [AW+BW-1:0] product_o
);

  localparam int unsigned CW = $clog2(BW + 1);

  logic          busy_q;
  logic [CW-1:0] cnt_q;
  logic [AW-1:0] a_q;
  logic [AW:0]   hi_q;
  logic [BW-1:0] lo_q;
  logic [AW:0]   acc;

  // add multiplicand when the current multiplier bit is set
  assign acc = lo_q[0] ? (hi_q + {1'b0, a_q}) : hi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CW'(BW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q  <= a_i;
      hi_q <= '0;
      lo_q <= b_i;
    end else if (busy_q) begin
      hi_q <= {1'b0, acc[AW:1]};
      lo_q <= {acc[0], lo_q[BW-1:1]};
    end
  end

  assign busy_o    = busy_q;
  assign product_o = {hi_q[AW-1:0], lo_q};

endmodule

// File: sv/swmv_div.sv
// ----------------------------------------------------------------------------
// swmv_div: bit-serial restoring divider
// One quotient bit per cycle, dividend MSB first. Divisor must be nonzero.
// ----------------------------------------------------------------------------
module swmv_div #(
  parameter int unsigned DW = 18,
  parameter int unsigned VW = 3
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          busy_o,
  output logic [DW-1:0] quotient_o
);

  localparam int unsigned CW = $clog2(DW + 1);

  logic          busy_q;
  logic [CW-1:0] cnt_q;
  logic [VW-1:0] div_q;
  logic [VW-1:0] rem_q;
  logic [DW-1:0] quo_q;
  logic [VW:0]   trial;
  logic [VW:0]   diff;
  logic          ge;

  assign trial = {rem_q, quo_q[DW-1]};
  assign diff  = trial - {1'b0, div_q};
  assign ge    = (trial >= {1'b0, div_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CW'(DW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // dividend shifts out at the top while quotient bits shift in below
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q <= divisor_i;
      rem_q <= '0;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[VW-1:0] : trial[VW-1:0];
      quo_q <= {quo_q[DW-2:0], ge};
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

// File: sv/sliding_window_mean_variance_core.sv
// ----------------------------------------------------------------------------
// sliding_window_mean_variance_core: moving mean and variance
// Running sum and sum of squares over the last WINDOW samples, with rounded
// mean and population variance produced by bit-serial arithmetic.
// ----------------------------------------------------------------------------
// Each accepted sample gives exactly one result: the rounded mean
// (sum + n/2) / n, the rounded population variance
// (n*sumsq - sum^2 + n^2/2) / n^2 and n itself, where n is the number of
// samples seen so far until WINDOW have arrived and WINDOW after that. Only
// the low SAMPLE_BITS bits of the sample are used. One transaction is worked
// on at a time and runs through three serial passes in a row before the
// next sample is taken: squaring the new and the leaving sample, squaring
// the window sum, and the variance division, one quotient bit per cycle. The
// result sits in an output register, so the next sample is taken while a
// result still waits for out_ready_i. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module sliding_window_mean_variance_core #(
  parameter int unsigned WINDOW      = 4,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [swmv_pkg::SAMPLE_W-1:0] sample_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [swmv_pkg::MEAN_W-1:0]   mean_o,
  output logic [swmv_pkg::VAR_W-1:0]    variance_o,
  output logic [swmv_pkg::FILL_W-1:0]   fill_count_o
);

  import swmv_pkg::*;

  localparam int unsigned LW    = $clog2(WINDOW);
  localparam int unsigned NW    = $clog2(WINDOW + 1);   // n and ring index
  localparam int unsigned CW    = $clog2(WINDOW + 2);   // seen count
  localparam int unsigned NN_W  = 2 * NW;
  localparam int unsigned SB    = SAMPLE_BITS;
  localparam int unsigned SUM_W = SB + LW;
  localparam int unsigned SQ_W  = 2 * SB + LW;
  localparam int unsigned SP_W  = 2 * SB + 2 * LW - 1;  // spread <= n^2*max^2/4
  localparam int unsigned MD_W  = SUM_W + 1;
  localparam int unsigned VD_W  = SP_W + 1;
  localparam int unsigned NSQ_W = SQ_W + NW;
  localparam int unsigned SS_W  = 2 * SUM_W;
  localparam int unsigned SPX_W = (NSQ_W > SS_W) ? NSQ_W : SS_W;
  localparam int unsigned MX_W  = (MD_W > MEAN_W) ? MD_W : MEAN_W;
  localparam int unsigned VX_W  = (VD_W > VAR_W) ? VD_W : VAR_W;
  localparam int unsigned FX_W  = (NW > FILL_W) ? NW : FILL_W;

  swmv_state_e state_q, state_d;

  // control state
  logic [CW-1:0]    seen_q;
  logic [NW-1:0]    widx_q;
  logic [SUM_W-1:0] sum_q;
  logic [SQ_W-1:0]  sq_q;
  logic             out_valid_q;

  // per-transaction payload
  logic [SB-1:0]    ring_q [WINDOW+1];
  logic [SB-1:0]    x_q;
  logic [SB-1:0]    old_q;
  logic             full_q;
  logic [NW-1:0]    n_q;
  logic [NN_W-1:0]  nn_q;
  logic [SP_W-1:0]  spread_q;
  logic [MEAN_W-1:0] mean_q;
  logic [VAR_W-1:0]  var_q;
  logic [FILL_W-1:0] fill_q;

  // sequencer strobes
  logic accept;
  logic sq_start, sp_start, div_start, load_out;

  // next ring slot, leaving slot and fill level
  logic [NW-1:0] widx_nx;
  logic [NW-1:0] old_slot;
  logic [CW-1:0] seen_nx;
  logic          full_nx;
  logic [SB-1:0] sample;
  logic [SB-1:0] old_eff;

  // unit results
  logic [2*SB-1:0]  x_sq, old_sq;
  logic [NSQ_W-1:0] nsq;
  logic [SS_W-1:0]  sum_sq;
  logic [SPX_W-1:0] spread_full;
  logic [MD_W-1:0]  mean_quo;
  logic [VD_W-1:0]  var_quo;
  logic [MX_W-1:0]  mean_ext;
  logic [VX_W-1:0]  var_ext;
  logic [FX_W-1:0]  fill_ext;
  logic bx, bo, bn, bs, bm, bv;

  assign sample   = sample_i[SB-1:0];
  assign accept   = in_valid_i && in_ready_o;
  assign widx_nx  = (widx_q == NW'(WINDOW)) ? '0 : widx_q + NW'(1);
  assign old_slot = (widx_nx == NW'(WINDOW)) ? '0 : widx_nx + NW'(1);
  assign seen_nx  = (seen_q == CW'(WINDOW + 1)) ? seen_q : seen_q + CW'(1);
  assign full_nx  = (seen_nx > CW'(WINDOW));
  // while filling nothing leaves the window
  assign old_eff  = full_q ? old_q : '0;

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    sq_start   = 1'b0;
    sp_start   = 1'b0;
    div_start  = 1'b0;
    load_out   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = ST_SQ;
        end
      end
      ST_SQ: begin
        sq_start = 1'b1;
        state_d  = ST_SQ_WAIT;
      end
      ST_SQ_WAIT: begin
        if (!(bx || bo)) begin
          state_d = ST_SP;
        end
      end
      ST_SP: begin
        sp_start = 1'b1;
        state_d  = ST_SP_WAIT;
      end
      ST_SP_WAIT: begin
        if (!(bn || bs)) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        div_start = 1'b1;
        state_d   = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (!(bm || bv)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // wait for a free output register
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // running totals and fill tracking
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q      <= '0;
      widx_q      <= NW'(WINDOW);
      sum_q       <= '0;
      sq_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        seen_q <= seen_nx;
        widx_q <= widx_nx;
      end
      // sum - old never goes negative: old is part of the window
      if (sq_start) begin
        sum_q <= sum_q - SUM_W'(old_eff) + SUM_W'(x_q);
      end
      if (state_q == ST_SQ_WAIT && !(bx || bo)) begin
        sq_q <= sq_q - SQ_W'(old_sq) + SQ_W'(x_sq);
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // sample ring: the leaving sample is read in the same cycle the new one
  // lands; the two slots always differ
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ring_q[widx_nx] <= sample;
      old_q           <= ring_q[old_slot];
      x_q             <= sample;
      full_q          <= full_nx;
      n_q             <= full_nx ? NW'(WINDOW) : NW'(seen_nx);
    end
  end

  always_ff @(posedge clk_i) begin
    if (sq_start) begin
      nn_q <= NN_W'(n_q) * NN_W'(n_q);
    end
    if (state_q == ST_SP_WAIT && !(bn || bs)) begin
      spread_q <= spread_full[SP_W-1:0];
    end
    if (load_out) begin
      mean_q <= mean_ext[MEAN_W-1:0];
      var_q  <= var_ext[VAR_W-1:0];
      fill_q <= fill_ext[FILL_W-1:0];
    end
  end

  assign spread_full = SPX_W'(nsq) - SPX_W'(sum_sq);
  assign mean_ext    = MX_W'(mean_quo);
  assign var_ext     = VX_W'(var_quo);
  assign fill_ext    = FX_W'(n_q);

  // --------------------------------------------------------------------------
  // serial units
  // --------------------------------------------------------------------------
  swmv_mul #(.AW(SB), .BW(SB)) u_mul_x (
    .clk_i, .rst_ni, .start_i(sq_start), .a_i(x_q), .b_i(x_q),
    .busy_o(bx), .product_o(x_sq)
  );

  swmv_mul #(.AW(SB), .BW(SB)) u_mul_old (
    .clk_i, .rst_ni, .start_i(sq_start), .a_i(old_eff), .b_i(old_eff),
    .busy_o(bo), .product_o(old_sq)
  );

  swmv_mul #(.AW(SQ_W), .BW(NW)) u_mul_nsq (
    .clk_i, .rst_ni, .start_i(sp_start), .a_i(sq_q), .b_i(n_q),
    .busy_o(bn), .product_o(nsq)
  );

  swmv_mul #(.AW(SUM_W), .BW(SUM_W)) u_mul_sum (
    .clk_i, .rst_ni, .start_i(sp_start), .a_i(sum_q), .b_i(sum_q),
    .busy_o(bs), .product_o(sum_sq)
  );

  swmv_div #(.DW(MD_W), .VW(NW)) u_div_mean (
    .clk_i, .rst_ni, .start_i(div_start),
    .dividend_i(MD_W'(sum_q) + MD_W'(n_q >> 1)),
    .divisor_i(n_q),
    .busy_o(bm), .quotient_o(mean_quo)
  );

  swmv_div #(.DW(VD_W), .VW(NN_W)) u_div_var (
    .clk_i, .rst_ni, .start_i(div_start),
    .dividend_i(VD_W'(spread_q) + VD_W'(nn_q >> 1)),
    .divisor_i(nn_q),
    .busy_o(bv), .quotient_o(var_quo)
  );

  assign out_valid_o  = out_valid_q;
  assign mean_o       = mean_q;
  assign variance_o   = var_q;
  assign fill_count_o = fill_q;

endmodule

// File: sim/tb_sliding_window_mean_variance_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sliding_window_mean_variance_core: self-checking bench for the core
// Streams samples through the valid/ready input, predicts mean, variance and
// fill count per transaction in a scoreboard, and checks every result in order
// under random source gaps and sink stalls.
// ----------------------------------------------------------------------------
module tb_sliding_window_mean_variance_core;
  import swmv_pkg::*;

  localparam int unsigned WINDOW      = 4;
  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned RING_SLOTS  = WINDOW + 1;
  // Accept-to-accept time of one transaction when the output does not stall.
  localparam int unsigned ITEM_CYCLES = 78;
  localparam int unsigned N_DIRECTED  = 23;
  localparam int unsigned N_RANDOM    = 1127;
  // Last stretch of the random part runs with no gaps and no stalls.
  localparam int unsigned N_QUIET     = 150;

  typedef struct packed {
    logic [MEAN_W-1:0] mean;
    logic [VAR_W-1:0]  variance;
    logic [FILL_W-1:0] fill_count;
  } window_stats_t;

  // --------------------------------------------------------------------------
  // Scoreboard: shadow copy of the window state plus the queue of stats still
  // owed by the core. Totals are kept at the core's widths; a transient carry
  // past the top bit cancels once the leaving sample is subtracted.
  // --------------------------------------------------------------------------
  class window_stats_board;
    logic [SAMPLE_W-1:0] ring [RING_SLOTS];
    int unsigned         wr_slot;
    int unsigned         seen;
    bit [17:0]           win_sum;
    bit [33:0]           win_sq_sum;
    window_stats_t       pending_stats_q [$];
    int unsigned         errors;

    function new();
      wr_slot    = WINDOW;   // first write lands in slot 0
      seen       = 0;
      win_sum    = '0;
      win_sq_sum = '0;
      errors     = 0;
    endfunction

    function int unsigned pending();
      return pending_stats_q.size();
    endfunction

    // Accepted input transaction: update the window and queue its stats.
    function void note_sample(logic [SAMPLE_W-1:0] raw);
      logic [SAMPLE_W-1:0] s;
      logic [SAMPLE_W-1:0] leaving;
      longint unsigned     n;
      longint unsigned     nn;
      longint unsigned     spread;
      window_stats_t       want;
      s = raw & SAMPLE_W'((1 << SAMPLE_BITS) - 1);
      if (seen < RING_SLOTS) seen++;
      wr_slot = (wr_slot < WINDOW) ? wr_slot + 1 : 0;
      ring[wr_slot] = s;
      win_sum    += 18'(s);
      win_sq_sum += 34'(s) * 34'(s);
      if (seen <= WINDOW) begin
        n = seen;
      end else begin
        // Slot after the write pointer holds the sample that just left.
        leaving     = ring[(wr_slot + 1) % RING_SLOTS];
        win_sum    -= 18'(leaving);
        win_sq_sum -= 34'(leaving) * 34'(leaving);
        n = WINDOW;
      end
      nn     = n * n;
      spread = n * 64'(win_sq_sum) - 64'(win_sum) * 64'(win_sum);
      want.mean       = MEAN_W'((64'(win_sum) + n / 2) / n);
      want.variance   = VAR_W'((spread + nn / 2) / nn);
      want.fill_count = FILL_W'(n);
      pending_stats_q.push_back(want);
    endfunction

    // Accepted output transaction: compare against the oldest prediction.
    function void check_result(logic [MEAN_W-1:0] mean, logic [VAR_W-1:0] variance,
                               logic [FILL_W-1:0] fill_count);
      window_stats_t want;
      if (pending_stats_q.size() == 0) begin
        $error("result with nothing pending: mean %0d variance %0d fill_count %0d",
               mean, variance, fill_count);
        errors++;
        return;
      end
      want = pending_stats_q.pop_front();
      if (mean !== want.mean) begin
        $error("mean: expected %0d, got %0d", want.mean, mean);
        errors++;
      end
      if (variance !== want.variance) begin
        $error("variance: expected %0d, got %0d", want.variance, variance);
        errors++;
      end
      if (fill_count !== want.fill_count) begin
        $error("fill_count: expected %0d, got %0d", want.fill_count, fill_count);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and DUT
  // --------------------------------------------------------------------------
  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  logic [SAMPLE_W-1:0] sample_i    = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [MEAN_W-1:0]   mean_o;
  logic [VAR_W-1:0]    variance_o;
  logic [FILL_W-1:0]   fill_count_o;

  // Set for the tail of the run: both sides stop idling.
  bit                  quiet = 1'b0;
  logic [SAMPLE_W-1:0] last_sample = '0;

  window_stats_board board = new();

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  sliding_window_mean_variance_core #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .sample_i     (sample_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .mean_o       (mean_o),
    .variance_o   (variance_o),
    .fill_count_o (fill_count_o)
  );

  // --------------------------------------------------------------------------
  // Monitor: both handshakes are sampled at the rising edge, before any of
  // this edge's nonblocking updates land, so what is seen is what was accepted.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) board.note_sample(sample_i);
      if (out_valid_o && out_ready_i) board.check_result(mean_o, variance_o, fill_count_o);
    end
  end

  // --------------------------------------------------------------------------
  // Sink: ready is mostly high, with stalls made of random bursts. Bursts
  // can run back to back, so a stall can outlast one whole transaction and
  // force the core to hold a result while the next sample waits.
  // --------------------------------------------------------------------------
  initial begin : sink
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!quiet && $urandom_range(0, 9) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 6)) repeat ($urandom_range(1, 18)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  // Present one sample and hold it until the core takes it. Returns in the
  // time step of the accepting edge, so a following call keeps valid high.
  task automatic send_sample(input logic [SAMPLE_W-1:0] s);
    in_valid_i <= 1'b1;
    sample_i   <= s;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Source gap: one or more bursts of idle cycles. Several bursts in
  // a row reach past the core's own busy time, so gaps land on every phase.
  task automatic source_gap();
    if (!quiet && $urandom_range(0, 2) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
  endtask

  // Random sample with a bias toward the corners: extremes, tiny values,
  // values just under full scale, and repeats that give zero variance.
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return SAMPLE_W'($urandom_range(0, 15));
      1:       return $urandom_range(0, 1) ? '1 : '0;
      2:       return SAMPLE_W'(16'hFFFF - $urandom_range(0, 15));
      3:       return last_sample;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [SAMPLE_W-1:0] directed [N_DIRECTED];
    logic [SAMPLE_W-1:0] s;

    // Filling window with alternating extremes, then steady state: alternating
    // extremes again (largest variance), a full-scale run and a zero run
    // (zero variance), small values that exercise rounding, and bit patterns.
    directed = '{16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000,
                 16'hFFFF, 16'h0000,
                 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                 16'h0001, 16'h0002, 16'h0001, 16'h0002,
                 16'h8000, 16'h7FFF, 16'hAAAA, 16'h5555, 16'h0003};

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) begin
      send_sample(directed[i]);
      source_gap();
    end

    for (int unsigned i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM / 2) begin
        // Let the core drain completely before carrying on. Wait on the clock first,
        // so the monitor has noted the transaction just accepted.
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (board.pending() != 0) @(posedge clk_i);
      end
      if (i == N_RANDOM - N_QUIET) quiet = 1'b1;
      s = pick_sample();
      last_sample = s;
      send_sample(s);
      source_gap();
    end
    in_valid_i <= 1'b0;

    @(posedge clk_i);
    while (board.pending() != 0) @(posedge clk_i);
    // Any stray extra result would show up before the wait below ends.
    repeat (2 * ITEM_CYCLES) @(posedge clk_i);

    if (board.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run.
  initial begin : watchdog
    #10ms;
    $display("FAIL");
    $finish;
  end

endmodule
